// ===== rtl/gf2pf_pkg.sv =====
package gf2pf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FACTOR,
    ST_LAST
  } state_t;

endpackage

// ===== rtl/gf2pf_divider.sv =====
module gf2pf_divider #(
  parameter int WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [WIDTH-1:0]          dividend,
  input  logic [WIDTH-1:0]          divisor,
  input  logic [$clog2(WIDTH)-1:0]  dividend_deg,
  input  logic [$clog2(WIDTH)-1:0]  shift,
  output logic                      done,
  output logic [WIDTH-1:0]          quotient,
  output logic                      rem_zero
);

  localparam int DW = $clog2(WIDTH);

  logic             busy_r;
  logic             busy_nxt;
  logic             done_r;
  logic             done_nxt;
  logic [DW-1:0]    cnt_r;
  logic [DW-1:0]    cnt_nxt;
  logic [DW-1:0]    pos_r;
  logic [DW-1:0]    pos_nxt;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] quo_r;
  logic [WIDTH-1:0] quo_nxt;
  logic [WIDTH-1:0] dsr_r;
  logic [WIDTH-1:0] dsr_nxt;
  logic             hit;

  assign hit = rem_r[pos_r];

  // one shift-and-xor step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = shift;
      pos_nxt  = dividend_deg;
      rem_nxt  = dividend;
      quo_nxt  = '0;
      dsr_nxt  = divisor << shift;
    end else if (busy_r) begin
      rem_nxt = hit ? (rem_r ^ dsr_r) : rem_r;
      quo_nxt = {quo_r[WIDTH-2:0], hit};
      dsr_nxt = dsr_r >> 1;
      pos_nxt = pos_r - {{(DW-1){1'b0}}, 1'b1};
      cnt_nxt = cnt_r - {{(DW-1){1'b0}}, 1'b1};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ===== rtl/gf2_poly_factorizer.sv =====
// operation: trial divisions run one after another through the shared
// bit-serial divider, with one output beat per emitted factor; worst case
// about 2^(WIDTH-1) trials
// throughput: one input beat per full factorization; the next beat is taken
// as soon as the final result sits in the output register
// reset: synchronous active-low rst_n clears the sequencer and output valid
module gf2_poly_factorizer #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_poly_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_factor,
  output logic             out_is_last
);

  import gf2pf_pkg::*;

  localparam int DW = $clog2(WIDTH);

  state_t           state_r;
  state_t           state_nxt;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dvs_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [WIDTH-1:0] out_factor_r;
  logic             out_is_last_r;

  logic [DW-1:0]    rem_deg;
  logic [DW-1:0]    dvs_deg;
  logic             try_div;
  logic             slot_free;
  logic             div_done;
  logic             div_rem_zero;
  logic [WIDTH-1:0] div_quo;

  logic             take_in;
  logic             div_start;
  logic             inc_dvs;
  logic             load_factor;
  logic             load_last;

  function automatic logic [DW-1:0] deg_of(input logic [WIDTH-1:0] p);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 1; i < WIDTH; i++) begin
      if (p[i]) d = i[DW-1:0];
    end
    return d;
  endfunction

  assign rem_deg   = deg_of(rem_r);
  assign dvs_deg   = deg_of(dvs_r);
  assign try_div   = (dvs_deg < rem_deg);
  assign slot_free = !out_valid_r || !out_stall;

  gf2pf_divider #(
    .WIDTH(WIDTH)
  ) u_divider (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (div_start),
    .dividend     (rem_r),
    .divisor      (dvs_r),
    .dividend_deg (rem_deg),
    .shift        (rem_deg - dvs_deg),
    .done         (div_done),
    .quotient     (div_quo),
    .rem_zero     (div_rem_zero)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = try_div ? ST_DIV : ST_LAST;
      ST_DIV: begin
        if (div_done) state_nxt = div_rem_zero ? ST_FACTOR : ST_CHECK;
      end
      ST_FACTOR: if (slot_free) state_nxt = ST_CHECK;
      ST_LAST:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    take_in     = 1'b0;
    div_start   = 1'b0;
    inc_dvs     = 1'b0;
    load_factor = 1'b0;
    load_last   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        take_in  = in_valid;
      end
      ST_CHECK:  div_start   = try_div;
      ST_DIV:    inc_dvs     = div_done && !div_rem_zero;
      ST_FACTOR: load_factor = slot_free;
      ST_LAST:   load_last   = slot_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = load_factor || load_last || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      rem_r <= in_poly_in;
      dvs_r <= {{(WIDTH-2){1'b0}}, 2'b10};
    end else begin
      if (inc_dvs) dvs_r <= dvs_r + {{(WIDTH-1){1'b0}}, 1'b1};
      if (load_factor) rem_r <= div_quo;
    end
    if (load_factor) begin
      out_factor_r  <= dvs_r;
      out_is_last_r <= 1'b0;
    end else if (load_last) begin
      out_factor_r  <= rem_r;
      out_is_last_r <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_factor  = out_factor_r;
  assign out_is_last = out_is_last_r;

endmodule
